FILE: design/eit_pkg.sv
// Shared constants, types and the genre lookup for the EIT section parser.
// Used by eit_lookup and dvb_eit_section_parser.
package eit_pkg;

    localparam int SERVICE_SLOTS     = 16;
    localparam int MAX_SECTION_BYTES = 4096;
    localparam int SLOT_W = (SERVICE_SLOTS > 1) ? $clog2(SERVICE_SLOTS) : 1;
    localparam int USED_W = $clog2(SERVICE_SLOTS + 1);
    localparam int POS_W  = $clog2(MAX_SECTION_BYTES) + 1;
    localparam int KEY_W  = 48;
    localparam int SEEN_W = 256;

    localparam logic [7:0] TID_FIRST   = 8'h50;
    localparam logic [7:0] TID_END     = 8'h6F;
    localparam logic [7:0] TID_ACTUAL  = 8'h4E;
    localparam logic [7:0] TID_OTHER   = 8'h4F;
    localparam logic [7:0] CONTENT_TAG = 8'h54;

    typedef enum logic [2:0] {
        K_EVENT     = 3'd0,
        K_CONTENT   = 3'd1,
        K_NEW       = 3'd2,
        K_DUP       = 3'd3,
        K_REJECT    = 3'd4,
        K_MALFORMED = 3'd5,
        K_FULL      = 3'd6
    } t_kind;

    typedef struct packed {
        logic              start;
        logic              clear;
        logic [KEY_W-1:0]  key;
        logic [7:0]        sec;
    } t_lk_req;

    typedef struct packed {
        logic              done;
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
    } t_lk_rsp;

    // level1 nibble selects a mask, level2 nibble selects the bit
    function automatic logic genre_known(input logic [7:0] hi);
        logic [15:0] mask;
        begin
            unique case (hi[7:4])
                4'h1:    mask = 16'hC1FF;
                4'h2:    mask = 16'hC01F;
                4'h3:    mask = 16'hC00F;
                4'h4:    mask = 16'hCFFF;
                4'h5:    mask = 16'hC03F;
                4'h6:    mask = 16'hC07F;
                4'h7:    mask = 16'hCFFF;
                4'h8:    mask = 16'hC00F;
                4'h9:    mask = 16'hC0FF;
                4'hA:    mask = 16'hC0FF;
                4'hB:    mask = 16'hC00F;
                4'hE:    mask = 16'h8000;
                4'hF:    mask = 16'h8000;
                default: mask = 16'h0000;
            endcase
            return mask[hi[3:0]];
        end
    endfunction

endpackage

FILE: design/eit_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module eit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/eit_lookup.sv
// Service table: key search over slots and section bitmap update.
// Depends on eit_pkg and eit_ram (key memory and section bitmap memory).
module eit_lookup
    import eit_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_lk_req i_req,
    output t_lk_rsp o_rsp
);
    typedef enum logic [1:0] {L_IDLE, L_RD, L_CMP, L_MISS} t_lstate;

    t_lstate           r_state;
    logic [USED_W-1:0] r_used;
    logic [SLOT_W-1:0] r_idx;
    logic [KEY_W-1:0]  r_key;
    logic [7:0]        r_sec;
    t_lk_rsp           r_rsp;

    logic [KEY_W-1:0]  w_key_rd;
    logic [SEEN_W-1:0] w_seen_rd;
    logic [SEEN_W-1:0] w_bit;
    logic              w_hit;
    logic              w_full;
    logic              w_key_we;
    logic              w_seen_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [SEEN_W-1:0] w_seen_wd;

    assign w_bit  = SEEN_W'(1) << r_sec;
    assign w_hit  = (w_key_rd == r_key);
    assign w_full = (r_used >= USED_W'(SERVICE_SLOTS));

    always_comb begin
        w_key_we  = 1'b0;
        w_seen_we = 1'b0;
        w_waddr   = r_idx;
        w_seen_wd = w_seen_rd | w_bit;
        if (r_state == L_MISS && !w_full) begin
            w_key_we  = 1'b1;
            w_seen_we = 1'b1;
            w_waddr   = r_used[SLOT_W-1:0];
            w_seen_wd = w_bit;
        end else if (r_state == L_CMP && w_hit && ((w_seen_rd & w_bit) == '0)) begin
            w_seen_we = 1'b1;
        end
    end

    eit_ram #(.WIDTH(KEY_W), .DEPTH(SERVICE_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_raddr (r_idx),
        .o_rdata (w_key_rd)
    );

    eit_ram #(.WIDTH(SEEN_W), .DEPTH(SERVICE_SLOTS)) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (w_seen_we),
        .i_waddr (w_waddr),
        .i_wdata (w_seen_wd),
        .i_raddr (r_idx),
        .o_rdata (w_seen_rd)
    );

    // both memories read at r_idx, so the bitmap is ready with the key compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_used  <= '0;
            r_idx   <= '0;
            r_rsp   <= '0;
        end else begin
            r_rsp.done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_req.clear) begin
                        r_used <= '0;
                    end else if (i_req.start) begin
                        r_key   <= i_req.key;
                        r_sec   <= i_req.sec;
                        r_idx   <= '0;
                        r_state <= (r_used == '0) ? L_MISS : L_RD;
                    end
                end
                L_RD: begin
                    r_state <= L_CMP;
                end
                L_CMP: begin
                    if (w_hit) begin
                        r_rsp.done <= 1'b1;
                        r_rsp.slot <= r_idx;
                        r_rsp.kind <= ((w_seen_rd & w_bit) != '0) ? K_DUP : K_NEW;
                        r_state    <= L_IDLE;
                    end else if (USED_W'(r_idx) + USED_W'(1) == r_used) begin
                        r_state <= L_MISS;
                    end else begin
                        r_idx   <= r_idx + SLOT_W'(1);
                        r_state <= L_RD;
                    end
                end
                L_MISS: begin
                    r_rsp.done <= 1'b1;
                    r_state    <= L_IDLE;
                    if (w_full) begin
                        r_rsp.kind <= K_FULL;
                        r_rsp.slot <= '0;
                    end else begin
                        r_rsp.kind <= K_NEW;
                        r_rsp.slot <= r_used[SLOT_W-1:0];
                        r_used     <= r_used + USED_W'(1);
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_rsp = r_rsp;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(SERVICE_SLOTS))
        else $error("service count beyond table size");
    a_key_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_we |-> !w_full && r_state == L_MISS)
        else $error("key written into a full table");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp.done |-> r_state == L_IDLE)
        else $error("lookup response while still searching");
endmodule

FILE: design/dvb_eit_section_parser.sv
// EIT section parser: one section byte per request, up to two results each.
// A byte is accepted in S_IDLE and worked in S_WORK; its results then leave
// one at a time from S_EMIT, held while the output is not ready. The byte
// that ends the section header first waits in S_LOOK for the service search
// (a read and a compare per slot in use, an allocation on a miss if there
// is room), then one result. No new byte is accepted until the last is done.
// Reset: table empty, grab disabled, parser idle, no result pending.
module dvb_eit_section_parser
    import eit_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // data_byte[7:0], section_first[8]
    input  logic [0:0]   s_axis_tuser,   // func
    input  logic         s_axis_tlast,   // section_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // service_slot, event ident, start_mjd, start_time, duration, run state,
    // free_ca, content_code, genre_known (lowest first)
    output logic [111:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last
);
    typedef enum logic [1:0] {S_IDLE, S_WORK, S_LOOK, S_EMIT} t_state;
    typedef enum logic [2:0] {
        P_IDLE, P_DROP, P_HDR, P_EVHDR, P_DTAG, P_DLEN, P_DBODY
    } t_phase;

    t_state            r_state;
    logic              r_grab;
    logic              r_func, r_first, r_lastm;
    logic [7:0]        r_byte;
    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [3:0]        r_evcnt, n_evcnt;
    logic [7:0]        r_ev [12];
    logic [7:0]        n_ev [12];
    logic [11:0]       r_loop, n_loop;
    logic [7:0]        r_tag, n_tag;
    logic [7:0]        r_drem, n_drem;
    logic [8:0]        r_pair, n_pair;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [7:0]        r_sec, n_sec;
    logic [1:0]        r_npend, n_npend;
    t_kind             r_kind0, n_kind0, r_kind1, n_kind1;
    logic [15:0]       r_code, n_code;
    logic              r_known, n_known;
    logic              n_lookup;

    logic              r_ovalid, r_olast;
    logic [111:0]      r_otdata;
    t_kind             r_okind;

    t_lk_req           w_req;
    t_lk_rsp           w_rsp;
    logic [111:0]      w_tdata;
    logic              w_ev, w_ct;
    logic              w_load;
    logic [11:0]       w_dl;

    function automatic logic tid_ok(input logic [7:0] t);
        return (t >= TID_FIRST && t <= TID_END) || t == TID_ACTUAL || t == TID_OTHER;
    endfunction

    // one section byte: phase update and the results it causes
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_slot   = r_slot;
        n_evcnt  = r_evcnt;
        n_ev     = r_ev;
        n_loop   = r_loop;
        n_tag    = r_tag;
        n_drem   = r_drem;
        n_pair   = r_pair;
        n_key    = r_key;
        n_sec    = r_sec;
        n_npend  = 2'd0;
        n_kind0  = K_EVENT;
        n_kind1  = K_EVENT;
        n_code   = '0;
        n_known  = 1'b0;
        n_lookup = 1'b0;
        w_dl     = '0;
        if (r_first) begin
            n_pos   = '0;
            n_slot  = '0;
            n_evcnt = '0;
            n_loop  = '0;
            n_pair  = '0;
            n_phase = P_HDR;
            if (!r_grab || !tid_ok(r_byte)) begin
                n_kind0 = K_REJECT;
                n_npend = 2'd1;
                n_phase = P_DROP;
            end
        end
        if (!r_first && (r_phase == P_IDLE || r_phase == P_DROP)) begin
            if (r_lastm) begin
                n_phase = P_IDLE;
            end
        end else begin
            if (n_phase != P_DROP) begin
                if (n_pos >= POS_W'(MAX_SECTION_BYTES)) begin
                    if (n_npend == 2'd0) n_kind0 = K_MALFORMED;
                    else n_kind1 = K_MALFORMED;
                    n_npend = n_npend + 2'd1;
                    n_phase = P_DROP;
                end else begin
                    n_pos = n_pos + POS_W'(1);
                    unique case (n_phase)
                        P_HDR: begin
                            unique case (r_pos[3:0])
                                4'd3:    n_key[15:8]  = r_byte;
                                4'd4:    n_key[7:0]   = r_byte;
                                4'd6:    n_sec        = r_byte;
                                4'd8:    n_key[31:24] = r_byte;
                                4'd9:    n_key[23:16] = r_byte;
                                4'd10:   n_key[47:40] = r_byte;
                                4'd11:   n_key[39:32] = r_byte;
                                default: ;
                            endcase
                            if (n_pos == POS_W'(14) && !r_lastm) begin
                                n_lookup = 1'b1;
                            end
                        end
                        P_EVHDR: begin
                            n_ev[r_evcnt] = r_byte;
                            n_evcnt = r_evcnt + 4'd1;
                            if (n_evcnt == 4'd12) begin
                                w_dl    = {n_ev[10][3:0], n_ev[11]};
                                n_kind0 = K_EVENT;
                                n_npend = 2'd1;
                                n_evcnt = '0;
                                if (w_dl != '0) begin
                                    n_loop  = w_dl;
                                    n_phase = P_DTAG;
                                end
                            end
                        end
                        P_DTAG: begin
                            n_tag   = r_byte;
                            n_loop  = r_loop - 12'd1;
                            n_phase = (n_loop == '0) ? P_EVHDR : P_DLEN;
                        end
                        P_DLEN: begin
                            n_drem = r_byte;
                            n_pair = '0;
                            n_loop = r_loop - 12'd1;
                            if (n_loop == '0) n_phase = P_EVHDR;
                            else n_phase = (r_byte == '0) ? P_DTAG : P_DBODY;
                        end
                        P_DBODY: begin
                            n_loop = r_loop - 12'd1;
                            n_drem = r_drem - 8'd1;
                            if (r_tag == CONTENT_TAG) begin
                                if (r_pair[8]) begin
                                    n_kind0 = K_CONTENT;
                                    n_npend = 2'd1;
                                    n_code  = {r_pair[7:0], r_byte};
                                    n_known = genre_known(r_pair[7:0]);
                                    n_pair  = '0;
                                end else begin
                                    n_pair = {1'b1, r_byte};
                                end
                            end
                            if (n_loop == '0) n_phase = P_EVHDR;
                            else if (n_drem == '0) n_phase = P_DTAG;
                        end
                        default: n_phase = P_DROP;
                    endcase
                end
            end
            if (r_lastm) begin
                if (n_phase == P_HDR || n_phase == P_DTAG || n_phase == P_DLEN
                        || n_phase == P_DBODY) begin
                    if (n_phase == P_HDR) n_slot = '0;
                    if (n_npend == 2'd0) n_kind0 = K_MALFORMED;
                    else n_kind1 = K_MALFORMED;
                    n_npend = n_npend + 2'd1;
                end
                n_phase = P_IDLE;
            end
        end
    end

    assign w_req.start = (r_state == S_WORK) && !r_func && n_lookup;
    assign w_req.clear = (r_state == S_WORK) && r_func;
    assign w_req.key   = r_key;
    assign w_req.sec   = r_sec;

    eit_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // result word for the head of the pending list
    assign w_ev = (r_kind0 == K_EVENT) || (r_kind0 == K_CONTENT);
    assign w_ct = (r_kind0 == K_CONTENT);
    assign w_tdata = {
        7'd0,
        w_ct & r_known,
        w_ct ? r_code : 16'd0,
        w_ev ? {r_ev[10][4], r_ev[10][7:5]} : 4'd0,
        w_ev ? {r_ev[7], r_ev[8], r_ev[9]} : 24'd0,
        w_ev ? {r_ev[4], r_ev[5], r_ev[6]} : 24'd0,
        w_ev ? {r_ev[2], r_ev[3]} : 16'd0,
        w_ev ? {r_ev[0], r_ev[1]} : 16'd0,
        4'(r_slot)
    };
    assign w_load = (r_state == S_EMIT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_grab   <= 1'b0;
            r_phase  <= P_IDLE;
            r_pos    <= '0;
            r_slot   <= '0;
            r_evcnt  <= '0;
            r_loop   <= '0;
            r_tag    <= '0;
            r_drem   <= '0;
            r_pair   <= '0;
            r_npend  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 12; i++) r_ev[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_grab <= i_cfg_wdata;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func  <= s_axis_tuser[0];
                        r_byte  <= s_axis_tdata[7:0];
                        r_first <= s_axis_tdata[8];
                        r_lastm <= s_axis_tlast;
                        r_state <= S_WORK;
                    end
                end
                S_WORK: begin
                    if (r_func) begin
                        r_grab  <= 1'b1;
                        r_phase <= P_IDLE;
                        r_state <= S_IDLE;
                    end else begin
                        r_phase <= n_phase;
                        r_pos   <= n_pos;
                        r_slot  <= n_slot;
                        r_evcnt <= n_evcnt;
                        r_ev    <= n_ev;
                        r_loop  <= n_loop;
                        r_tag   <= n_tag;
                        r_drem  <= n_drem;
                        r_pair  <= n_pair;
                        r_key   <= n_key;
                        r_sec   <= n_sec;
                        r_npend <= n_npend;
                        r_kind0 <= n_kind0;
                        r_kind1 <= n_kind1;
                        r_code  <= n_code;
                        r_known <= n_known;
                        if (n_lookup) r_state <= S_LOOK;
                        else r_state <= (n_npend != 2'd0) ? S_EMIT : S_IDLE;
                    end
                end
                S_LOOK: begin
                    if (w_rsp.done) begin
                        r_slot  <= w_rsp.slot;
                        r_kind0 <= w_rsp.kind;
                        r_npend <= 2'd1;
                        r_evcnt <= '0;
                        r_phase <= (w_rsp.kind == K_NEW) ? P_EVHDR : P_DROP;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_otdata <= w_tdata;
                        r_okind  <= r_kind0;
                        r_olast  <= (r_npend == 2'd1);
                        r_kind0  <= r_kind1;
                        r_npend  <= r_npend - 2'd1;
                        if (r_npend == 2'd1) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_npend == 2'd0)
        else $error("accepting while results are pending");
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npend <= 2'd2)
        else $error("more than two results for one request");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_npend != 2'd0)
        else $error("emit state with nothing to send");
endmodule

FILE: tb/eit_checker.sv
// Scoreboard for the EIT section parser: watches both streams, keeps its own
// copy of the parser and service table state, and compares every result.
// Depends on eit_pkg for result kinds, table ids and sizes.
`timescale 1ns / 100ps
module eit_checker
    import eit_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [15:0]  i_s_tdata,
    input  logic [0:0]   i_s_tuser,
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [111:0] i_m_tdata,
    input  logic [2:0]   i_m_tuser,
    input  logic         i_m_tlast,
    output int           o_pending,
    output int           o_fail_count
);

    typedef enum {PH_IDLE, PH_DROP, PH_HDR, PH_EVHDR, PH_DTAG, PH_DLEN, PH_DBODY} t_parse_ph;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [15:0] ev_ident;
        logic [15:0] mjd;
        logic [23:0] stime;
        logic [23:0] dur;
        logic [2:0]  rstat;
        logic        fca;
        logic [15:0] code;
        logic        known;
        logic        lst;
    } t_eit_result;

    t_eit_result expected_q[$];
    t_eit_result step_q[$];

    logic              grab_en;
    logic [KEY_W-1:0]  svc_key [SERVICE_SLOTS];
    logic              svc_valid [SERVICE_SLOTS];
    logic [SEEN_W-1:0] svc_seen [SERVICE_SLOTS];
    int                svc_used;
    int                byte_pos;
    logic [7:0]        hdr [14];
    t_parse_ph         phase;
    logic [7:0]        ev_hdr [12];
    int                ev_cnt;
    int                loop_left;
    logic [15:0]       desc_tag_len;
    logic [7:0]        desc_left;
    logic [8:0]        pair_hi;
    int                cur_slot;
    int                fails;
    int                pend_cnt;

    assign o_pending    = pend_cnt;
    assign o_fail_count = fails;

    function automatic logic genre_lookup(input logic [7:0] hi);
        logic [15:0] bits;
        case (hi[7:4])
            4'h1:           bits = 16'hC1FF;
            4'h2:           bits = 16'hC01F;
            4'h3, 4'h8, 4'hB: bits = 16'hC00F;
            4'h4, 4'h7:     bits = 16'hCFFF;
            4'h5:           bits = 16'hC03F;
            4'h6:           bits = 16'hC07F;
            4'h9, 4'hA:     bits = 16'hC0FF;
            4'hE, 4'hF:     bits = 16'h8000;
            default:        bits = 16'h0000;
        endcase
        return bits[hi[3:0]];
    endfunction

    function automatic void emit(input t_kind kind, input bit with_ev,
                                 input logic [15:0] code, input logic known);
        t_eit_result r;
        r = '0;
        r.kind = kind;
        r.slot = cur_slot[3:0];
        if (with_ev) begin
            r.ev_ident = {ev_hdr[0], ev_hdr[1]};
            r.mjd      = {ev_hdr[2], ev_hdr[3]};
            r.stime    = {ev_hdr[4], ev_hdr[5], ev_hdr[6]};
            r.dur      = {ev_hdr[7], ev_hdr[8], ev_hdr[9]};
            r.rstat    = ev_hdr[10][7:5];
            r.fca      = ev_hdr[10][4];
        end
        r.code  = code;
        r.known = known;
        step_q.insert(step_q.size(), r);
    endfunction

    function automatic void find_service();
        logic [KEY_W-1:0] key;
        logic [7:0]       sec;
        bit               found;
        int               idx;
        key = {hdr[10], hdr[11], hdr[8], hdr[9], hdr[3], hdr[4]};
        sec = hdr[6];
        found = 0;
        idx = 0;
        for (int j = 0; j < SERVICE_SLOTS; j++)
            if (!found && svc_valid[j] && svc_key[j] == key) begin
                found = 1;
                idx = j;
            end
        if (!found) begin
            if (svc_used >= SERVICE_SLOTS) begin
                cur_slot = 0;
                emit(K_FULL, 0, 16'h0, 1'b0);
                phase = PH_DROP;
                return;
            end
            idx = svc_used;
            svc_used++;
            svc_key[idx]   = key;
            svc_valid[idx] = 1'b1;
            svc_seen[idx]  = '0;
        end
        cur_slot = idx;
        if (svc_seen[idx][sec]) begin
            emit(K_DUP, 0, 16'h0, 1'b0);
            phase = PH_DROP;
            return;
        end
        svc_seen[idx][sec] = 1'b1;
        emit(K_NEW, 0, 16'h0, 1'b0);
        ev_cnt = 0;
        phase = PH_EVHDR;
    endfunction

    function automatic void predict(input logic fn, input logic [7:0] b,
                                    input logic first, input logic lst);
        int          pos;
        logic [11:0] dl;
        step_q.delete();
        if (fn) begin
            foreach (svc_valid[j]) svc_valid[j] = 1'b0;
            svc_used = 0;
            phase = PH_IDLE;
            grab_en = 1'b1;
            return;
        end
        if (first) begin
            byte_pos = 0;
            cur_slot = 0;
            ev_cnt = 0;
            loop_left = 0;
            pair_hi = '0;
            phase = PH_HDR;
            if (!grab_en || !((b >= TID_FIRST && b <= TID_END) ||
                              b == TID_ACTUAL || b == TID_OTHER)) begin
                emit(K_REJECT, 0, 16'h0, 1'b0);
                phase = PH_DROP;
            end
        end else if (phase == PH_IDLE || phase == PH_DROP) begin
            if (lst) phase = PH_IDLE;
            return;
        end

        if (phase != PH_DROP) begin
            if (byte_pos >= MAX_SECTION_BYTES) begin
                emit(K_MALFORMED, 0, 16'h0, 1'b0);
                phase = PH_DROP;
            end else begin
                pos = byte_pos;
                byte_pos++;
                case (phase)
                    PH_HDR: begin
                        if (pos < 14) hdr[pos] = b;
                        if (pos == 13 && !lst) find_service();
                    end
                    PH_EVHDR: begin
                        ev_hdr[ev_cnt] = b;
                        ev_cnt++;
                        if (ev_cnt >= 12) begin
                            dl = {ev_hdr[10][3:0], ev_hdr[11]};
                            emit(K_EVENT, 1, 16'h0, 1'b0);
                            ev_cnt = 0;
                            if (dl > 0) begin
                                loop_left = dl;
                                phase = PH_DTAG;
                            end
                        end
                    end
                    PH_DTAG: begin
                        desc_tag_len = {b, 8'h00};
                        loop_left--;
                        phase = (loop_left == 0) ? PH_EVHDR : PH_DLEN;
                    end
                    PH_DLEN: begin
                        desc_tag_len[7:0] = b;
                        desc_left = b;
                        pair_hi = '0;
                        loop_left--;
                        if (loop_left == 0) phase = PH_EVHDR;
                        else phase = (b == 0) ? PH_DTAG : PH_DBODY;
                    end
                    PH_DBODY: begin
                        loop_left--;
                        desc_left--;
                        if (desc_tag_len[15:8] == CONTENT_TAG) begin
                            if (pair_hi[8]) begin
                                emit(K_CONTENT, 1, {pair_hi[7:0], b},
                                     genre_lookup(pair_hi[7:0]));
                                pair_hi = '0;
                            end else begin
                                pair_hi = {1'b1, b};
                            end
                        end
                        if (loop_left == 0) phase = PH_EVHDR;
                        else if (desc_left == 0) phase = PH_DTAG;
                    end
                    default: phase = PH_DROP;
                endcase
            end
        end

        if (lst) begin
            if (phase == PH_HDR) begin
                cur_slot = 0;
                emit(K_MALFORMED, 0, 16'h0, 1'b0);
            end else if (phase == PH_DTAG || phase == PH_DLEN || phase == PH_DBODY) begin
                emit(K_MALFORMED, 0, 16'h0, 1'b0);
            end
            phase = PH_IDLE;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endfunction

    initial begin
        fails = 0;
        pend_cnt = 0;
    end

    always @(posedge i_clk) begin
        t_eit_result e;
        if (!i_rst_n) begin
            grab_en = 1'b0;
            foreach (svc_valid[j]) begin
                svc_valid[j] = 1'b0;
                svc_key[j] = '0;
                svc_seen[j] = '0;
            end
            svc_used = 0;
            byte_pos = 0;
            foreach (hdr[j]) hdr[j] = '0;
            foreach (ev_hdr[j]) ev_hdr[j] = '0;
            phase = PH_IDLE;
            ev_cnt = 0;
            loop_left = 0;
            desc_tag_len = '0;
            desc_left = '0;
            pair_hi = '0;
            cur_slot = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) grab_en = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                predict(i_s_tuser[0], i_s_tdata[7:0], i_s_tdata[8], i_s_tlast);
                if (step_q.size() > 0) step_q[step_q.size()-1].lst = 1'b1;
                foreach (step_q[j]) expected_q.insert(expected_q.size(), step_q[j]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: kind %0d", i_m_tuser);
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("kind", e.kind, i_m_tuser);
                    check_field("service_slot", e.slot, i_m_tdata[3:0]);
                    check_field("evt_ident", e.ev_ident, i_m_tdata[19:4]);
                    check_field("start_mjd", e.mjd, i_m_tdata[35:20]);
                    check_field("start_time", e.stime, i_m_tdata[59:36]);
                    check_field("duration", e.dur, i_m_tdata[83:60]);
                    check_field("run_state", e.rstat, i_m_tdata[86:84]);
                    check_field("free_ca", e.fca, i_m_tdata[87]);
                    check_field("content_code", e.code, i_m_tdata[103:88]);
                    check_field("genre_known", e.known, i_m_tdata[104]);
                    check_field("last", e.lst, i_m_tlast);
                end
            end
        end
        pend_cnt = expected_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the EIT section parser bench: clock, reset, section stimulus,
// output back-pressure and verdict. Checking is done in eit_checker.
`timescale 1ns / 100ps
module testbench
    import eit_pkg::*;
();

    localparam int TOTAL_ITEMS = 1800;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;    // data_byte, section_first (lowest first)
    logic [0:0]   s_tuser = '0;    // func
    logic         s_tlast = 1'b0;  // section_last
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;         // slot, event fields, content_code, genre_known
    logic [2:0]   m_tuser;         // kind
    logic         m_tlast;
    int           pending;
    int           fail_count;
    int           items = 0;
    int           cycles = 0;
    bit           quiet = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    dvb_eit_section_parser uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser), .s_axis_tlast(s_tlast),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast)
    );

    eit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    int rdy_hold = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            m_tready <= 1'b1;
            rdy_hold = 0;
        end else if (rdy_hold > 0) begin
            rdy_hold--;
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready <= 1'b0;
            rdy_hold = $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
            rdy_hold = $urandom_range(0, 20);
        end
    end

    task automatic send(input logic fn, input logic [7:0] b, input logic first,
                        input logic lst);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, first, b};
        s_tuser  <= fn;
        s_tlast  <= lst;
        do @(posedge i_clk); while (!s_tready);
        items++;
    endtask

    // drain: all results in, then allow for a service search still running
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_grab(input logic v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_section(input int key_id, input int secnum, input int n_ev,
                                input bit bad_tid, input int trunc, input bit no_last);
        logic [7:0]  q[$];
        logic [7:0]  dsc[$];
        logic [7:0]  tid;
        logic [47:0] key;
        int          dl;
        int          cut;
        int          len;
        int          nd;
        if (bad_tid) begin
            do tid = 8'($urandom);
            while ((tid >= TID_FIRST && tid <= TID_END) || tid == TID_ACTUAL ||
                   tid == TID_OTHER);
        end else begin
            case ($urandom_range(0, 3))
                0: tid = TID_ACTUAL;
                1: tid = TID_OTHER;
                2: tid = TID_FIRST + 8'($urandom_range(0, 31));
                default: tid = TID_END;
            endcase
        end
        key = 48'(key_id) * 48'h9E37_79B9_7F4B;
        q.insert(q.size(), tid);
        q.insert(q.size(), 8'($urandom));
        q.insert(q.size(), 8'($urandom));
        q.insert(q.size(), key[15:8]);
        q.insert(q.size(), key[7:0]);
        q.insert(q.size(), 8'($urandom));
        q.insert(q.size(), 8'(secnum));
        q.insert(q.size(), 8'($urandom));
        q.insert(q.size(), key[31:24]);
        q.insert(q.size(), key[23:16]);
        q.insert(q.size(), key[47:40]);
        q.insert(q.size(), key[39:32]);
        q.insert(q.size(), 8'($urandom));
        q.insert(q.size(), 8'($urandom));
        for (int e = 0; e < n_ev; e++) begin
            repeat (10) q.insert(q.size(), 8'($urandom));
            dsc.delete();
            nd = $urandom_range(0, 3);
            for (int d = 0; d < nd; d++) begin
                dsc.insert(dsc.size(),
                           ($urandom_range(0, 2) != 0) ? CONTENT_TAG : 8'($urandom));
                len = $urandom_range(0, 7);
                dsc.insert(dsc.size(), 8'(len));
                repeat (len) dsc.insert(dsc.size(), 8'($urandom));
            end
            dl = dsc.size();
            // cut the loop short so the last descriptor overruns it
            cut = $urandom_range(1, 3);
            if (dl > cut && $urandom_range(0, 4) == 0) dl -= cut;
            while (dsc.size() > dl) void'(dsc.pop_back());
            q.insert(q.size(), {3'($urandom), 1'($urandom), 4'(dl >> 8)});
            q.insert(q.size(), 8'(dl));
            foreach (dsc[j]) q.insert(q.size(), dsc[j]);
        end
        repeat (4) q.insert(q.size(), 8'($urandom));
        if (trunc > 0 && trunc < q.size())
            while (q.size() > trunc) void'(q.pop_back());
        foreach (q[j])
            send(1'b0, q[j], j == 0, !no_last && j == q.size() - 1);
    endtask

    initial begin
        int r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grab still disabled after reset
        send_section(1, 0, 1, 0, 0, 0);
        write_grab(1'b1);
        send_section(1, 0, 2, 0, 0, 0);
        send_section(1, 0, 1, 0, 0, 0);          // duplicate
        send_section(1, 1, 2, 0, 0, 0);
        send_section(2, 255, 1, 1, 0, 0);        // bad table id
        send_section(3, 7, 1, 0, 6, 0);          // short section
        send_section(3, 7, 2, 0, 0, 1);          // abandoned by next start
        send(1'b0, 8'hFF, 1'b0, 1'b1);           // stray byte
        send_section(4, 2, 3, 0, 30, 0);         // ends inside a loop or header
        send(1'b1, 8'hA5, 1'b1, 1'b1);           // restart
        send_section(1, 0, 1, 0, 0, 0);

        // section running past the size limit, all-zero events
        for (int j = 0; j < MAX_SECTION_BYTES + 4; j++)
            send(1'b0, (j == 0) ? TID_ACTUAL : ((j == 6) ? 8'd9 : 8'h00),
                 j == 0, j == MAX_SECTION_BYTES + 3);
        write_grab(1'b0);
        send_section(5, 0, 1, 0, 0, 0);
        write_grab(1'b1);

        // fill the service table past its end
        for (int k = 0; k <= SERVICE_SLOTS; k++)
            send_section(100 + k, k, ($urandom_range(0, 1)), 0, 0, 0);
        write_grab(1'b1);

        while (items < TOTAL_ITEMS + MAX_SECTION_BYTES) begin
            if (items > TOTAL_ITEMS * 85 / 100 + MAX_SECTION_BYTES) quiet = 1;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_section($urandom_range(0, 19),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 3),
                             $urandom_range(0, 3), 0, 0, 0);
            end else if (r < 80) begin
                send_section($urandom_range(0, 19), $urandom_range(0, 255),
                             $urandom_range(1, 3), $urandom_range(0, 5) == 0,
                             $urandom_range(1, 60), $urandom_range(0, 2) == 0);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 5))
                    send(1'b0, 8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
            end else if (r < 93) begin
                send(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (r < 96) begin
                write_grab($urandom_range(0, 3) != 0);
            end else begin
                wait_idle();
            end
        end

        quiet = 1;
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
